// ===== sv/slotted_page_record_engine_core_defines.svh =====
// Assertion helpers for the slotted page record engine.
`ifndef SLOTTED_PAGE_RECORD_ENGINE_CORE_DEFINES_SVH
`define SLOTTED_PAGE_RECORD_ENGINE_CORE_DEFINES_SVH

// Implication in the same cycle, clocked by clk, off during reset.
`define SPRE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spre check failed");

// Implication in the next cycle.
`define SPRE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spre check failed");

`endif

// ===== sv/spre_pkg.sv =====
package spre_pkg;

	localparam int HEADER_BYTES = 5;
	localparam int DESC_BYTES   = 10;

	typedef enum logic [2:0] {
		CMD_INIT   = 3'd0,
		CMD_FIND   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_UPDATE = 3'd3,
		CMD_DATA   = 3'd4,
		CMD_DELETE = 3'd5,
		CMD_READ   = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_NO_SPACE  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCAN_TEST,
		S_SCAN,
		S_SCAN_CHK,
		S_DEL_START,
		S_MV1_RD,
		S_MV1_WR,
		S_MV2_START,
		S_MV2_RD,
		S_MV2_WR,
		S_ZERO_START,
		S_ZERO,
		S_WR_START,
		S_WR_DESC,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] key;
		logic [11:0] length;
		logic [7:0]  data_byte;
		logic [11:0] offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] record_offset;
		logic [11:0] record_length;
		logic [7:0]  read_data;
		logic [11:0] free_space;
		logic [11:0] fill_location;
		logic        dirty;
	} rsp_t;

endpackage

// ===== sv/spre_ram.sv =====
module spre_ram #(
	parameter int DEPTH = 4091,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);
	localparam int IW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we && (32'(addr) < DEPTH)) begin
			mem[addr[IW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= (32'(addr) < DEPTH) ? mem[addr[IW-1:0]] : 8'd0;
		end
	end
endmodule

// ===== sv/slotted_page_record_engine_core.sv =====
// Data byte: no result. Read byte, init and write header: one result each.
// Find reads each descriptor in turn until one matches (byte-wide port).
// Delete is find, then it moves data bytes, moves descriptor bytes and zeroes freed bytes.
// Update is find, plus delete and a write (skipped with no space) when the size changes.
// A result beat that is not taken holds the block in its last cycle.
// After reset the store is zeroed, one byte a cycle, no beats taken.
`include "slotted_page_record_engine_core_defines.svh"

module slotted_page_record_engine_core #(
	parameter int BLOCK_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  spre_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output spre_pkg::rsp_t rsp
);
	import spre_pkg::*;

	localparam int STORE = BLOCK_BYTES - HEADER_BYTES;
	localparam int CW    = $clog2(BLOCK_BYTES) + 1;
	localparam logic [CW-1:0] STORE_C = CW'(STORE);
	localparam logic [CW-1:0] DESC_C  = CW'(DESC_BYTES);

	fsm_t state_q, state_d;

	logic [CW-1:0] free_q, dend_q, pwp_q, pos_q, off_q, rec_q, cur_q, dst_q, end_q;
	logic [11:0]   pbl_q, length_q;
	logic [15:0]   len_q, rlen_q;
	logic [CW-1:0] roff_q;
	logic [3:0]    j_q;
	logic [79:0]   desc_q, desc_w, wdesc_w;
	logic [63:0]   key_q;
	cmd_t          cmd_q;
	status_t       status_q;
	logic [7:0]    rdata_q;
	logic          dirty_q, rd_in_q, rd_vld_s1, rsp_valid_q;
	rsp_t          rsp_q;

	logic          mem_we, mem_re;
	logic [CW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;

	logic [CW-1:0] stop_w, src_w, dlen_w, nfree_w, ndend_w;
	logic          found_w, nospace_w, slot_free_w;

	spre_ram #(.DEPTH(STORE), .AW(CW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign desc_w      = {mem_rdata, desc_q[79:8]};
	assign wdesc_w     = {4'd0, length_q, key_q};
	assign stop_w      = dend_q + free_q;
	assign found_w     = (desc_w[63:0] == key_q);
	assign dlen_w      = CW'(desc_w[79:64]);
	assign src_w       = rec_q + CW'(len_q);
	assign nfree_w     = free_q + CW'(len_q) + DESC_C;
	assign ndend_w     = (dend_q >= CW'(len_q)) ? dend_q - CW'(len_q) : '0;
	assign nospace_w   = 32'(free_q) < (32'(length_q) + 32'(DESC_BYTES));
	assign slot_free_w = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = cur_q;
		mem_wdata = 8'd0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (cur_q == STORE_C - CW'(1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					unique case (cmd_t'(req.command))
						CMD_DATA: begin
							mem_we    = (pbl_q != 12'd0);
							mem_addr  = pwp_q;
							mem_wdata = req.data_byte;
						end
						CMD_READ: begin
							mem_re   = 1'b1;
							mem_addr = CW'(req.offset);
							state_d  = S_READ;
						end
						CMD_FIND, CMD_UPDATE, CMD_DELETE: state_d = S_SCAN_TEST;
						CMD_WRITE: state_d = S_WR_START;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_READ: state_d = S_FINISH;
			S_SCAN_TEST: begin
				state_d = (pos_q >= stop_w + DESC_C) ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				mem_re   = 1'b1;
				mem_addr = pos_q + CW'(j_q);
				if (j_q == 4'd9) state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (found_w) begin
					unique case (cmd_q)
						CMD_DELETE: state_d = S_DEL_START;
						CMD_UPDATE: begin
							state_d = (desc_w[79:64] == {4'd0, length_q}) ? S_FINISH
								: S_DEL_START;
						end
						default: state_d = S_FINISH;
					endcase
				end else begin
					state_d = S_SCAN_TEST;
				end
			end
			S_DEL_START: state_d = (src_w < dend_q) ? S_MV1_RD : S_MV2_START;
			S_MV1_RD: begin
				mem_re  = 1'b1;
				state_d = S_MV1_WR;
			end
			S_MV1_WR: begin
				mem_we    = 1'b1;
				mem_addr  = dst_q;
				mem_wdata = mem_rdata;
				state_d   = (cur_q + CW'(1) == dend_q) ? S_MV2_START : S_MV1_RD;
			end
			S_MV2_START: state_d = (pos_q > stop_w) ? S_MV2_RD : S_ZERO_START;
			S_MV2_RD: begin
				mem_re  = 1'b1;
				state_d = S_MV2_WR;
			end
			S_MV2_WR: begin
				mem_we    = 1'b1;
				mem_addr  = cur_q + DESC_C;
				mem_wdata = mem_rdata;
				state_d   = (cur_q == stop_w) ? S_ZERO_START : S_MV2_RD;
			end
			S_ZERO_START: state_d = S_ZERO;
			S_ZERO: begin
				mem_we = 1'b1;
				if (cur_q + CW'(1) == end_q) begin
					state_d = (cmd_q == CMD_UPDATE) ? S_WR_START : S_FINISH;
				end
			end
			S_WR_START: state_d = nospace_w ? S_FINISH : S_WR_DESC;
			S_WR_DESC: begin
				mem_we    = 1'b1;
				mem_addr  = pos_q + CW'(j_q);
				mem_wdata = wdesc_w[j_q*8 +: 8];
				if (j_q == 4'd9) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free_w) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= STORE_C;
			dend_q      <= '0;
			dirty_q     <= 1'b1;
			pwp_q       <= '0;
			pbl_q       <= 12'd0;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (state_q == S_FINISH && slot_free_w) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: cur_q <= cur_q + CW'(1);
				S_IDLE: begin
					if (req_valid) begin
						unique case (cmd_t'(req.command))
							CMD_INIT: begin
								free_q  <= STORE_C;
								dend_q  <= '0;
								dirty_q <= 1'b1;
								pbl_q   <= 12'd0;
							end
							CMD_DATA: begin
								if (pbl_q != 12'd0) begin
									pwp_q <= pwp_q + CW'(1);
									pbl_q <= pbl_q - 12'd1;
								end
							end
							CMD_WRITE, CMD_UPDATE, CMD_DELETE: pbl_q <= 12'd0;
							default: ;
						endcase
					end
				end
				S_SCAN_CHK: begin
					if (found_w && cmd_q == CMD_UPDATE &&
						desc_w[79:64] == {4'd0, length_q}) begin
						pwp_q   <= off_q;
						pbl_q   <= length_q;
						dirty_q <= 1'b1;
					end
				end
				S_DEL_START: cur_q <= src_w;
				S_MV1_WR: cur_q <= cur_q + CW'(1);
				S_MV2_START: cur_q <= pos_q - CW'(1);
				S_MV2_WR: cur_q <= cur_q - CW'(1);
				S_ZERO_START: begin
					free_q  <= nfree_w;
					dend_q  <= ndend_w;
					cur_q   <= ndend_w;
					dirty_q <= 1'b1;
				end
				S_ZERO: cur_q <= cur_q + CW'(1);
				S_WR_START: begin
					if (!nospace_w) begin
						pwp_q   <= dend_q;
						pbl_q   <= length_q;
						free_q  <= free_q - CW'(length_q) - DESC_C;
						dend_q  <= dend_q + CW'(length_q);
						dirty_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) desc_q <= desc_w;
		unique case (state_q)
			S_IDLE: begin
				cmd_q    <= cmd_t'(req.command);
				key_q    <= req.key;
				length_q <= req.length;
				status_q <= STS_OK;
				roff_q   <= '0;
				rlen_q   <= 16'd0;
				rdata_q  <= 8'd0;
				pos_q    <= STORE_C;
				off_q    <= '0;
				rd_in_q  <= (32'(req.offset) < STORE);
			end
			S_READ: rdata_q <= rd_in_q ? mem_rdata : 8'd0;
			S_SCAN_TEST: begin
				if (pos_q >= stop_w + DESC_C) begin
					pos_q <= pos_q - DESC_C;
					j_q   <= 4'd0;
				end else begin
					status_q <= STS_NOT_FOUND;
				end
			end
			S_SCAN: j_q <= j_q + 4'd1;
			S_SCAN_CHK: begin
				if (found_w) begin
					rec_q  <= off_q;
					len_q  <= desc_w[79:64];
					roff_q <= off_q;
					rlen_q <= desc_w[79:64];
				end else begin
					off_q <= off_q + dlen_w;
				end
			end
			S_DEL_START: dst_q <= rec_q;
			S_MV1_WR: dst_q <= dst_q + CW'(1);
			S_ZERO_START: end_q <= ndend_w + nfree_w;
			S_WR_START: begin
				if (nospace_w) begin
					status_q <= STS_NO_SPACE;
					roff_q   <= '0;
					rlen_q   <= 16'd0;
				end else begin
					roff_q <= dend_q;
					rlen_q <= {4'd0, length_q};
					pos_q  <= dend_q + free_q - DESC_C;
					j_q    <= 4'd0;
				end
			end
			S_WR_DESC: j_q <= j_q + 4'd1;
			S_FINISH: begin
				if (slot_free_w) begin
					rsp_q.status        <= status_q;
					rsp_q.record_offset <= 12'(roff_q);
					rsp_q.record_length <= rlen_q[11:0];
					rsp_q.read_data     <= rdata_q;
					rsp_q.free_space    <= 12'(free_q);
					rsp_q.fill_location <= 12'(dend_q);
					rsp_q.dirty         <= dirty_q;
				end
			end
			default: ;
		endcase
	end

	`SPRE_ASSERT_IMP(a_idle_bounds, state_q == S_IDLE, 32'(dend_q) + 32'(free_q) <= STORE)
	`SPRE_ASSERT_IMP(a_pending_in_store, pbl_q != 12'd0, 32'(pwp_q) + 32'(pbl_q) <= STORE)
	`SPRE_ASSERT_NXT(a_finish_loads, state_q == S_FINISH && slot_free_w, rsp_valid_q)
endmodule
